// ----- rtl/core/itrd_pkg.sv -----
package itrd_pkg;

  // configuration register widths and indexes
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned SYM_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [SYM_W-1:0]   SYM_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [SYM_W-1:0]   SYM_HIGH_RST = 64'h0000_0000_0000_3938;

  // symbol table and limits
  localparam int unsigned MAX_RADIX  = 16;
  localparam int unsigned MAX_CHARS  = 33;
  localparam int unsigned NUM_SYMS   = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIGITS     = MAX_CHARS - 1;
  localparam int unsigned DIG_IDX_W  = $clog2(DIGITS);
  localparam int unsigned CNT_W      = $clog2(DIGITS + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_EMPTY
  } itrd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic emit_sign;
    logic emit_digit;
    logic emit_empty;
  } itrd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic table_ok;
    logic div_done;
    logic neg;
    logic out_free;
    logic emit_last;
  } itrd_stat_t;

endpackage

// ----- rtl/core/itrd_ctrl.sv -----
module itrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itrd_pkg::itrd_stat_t st,
  output itrd_pkg::itrd_cmd_t  cmd
);

  itrd_pkg::itrd_state_t state_r, state_nxt;
  logic [1:0]            byte_cnt_r, byte_cnt_nxt;

  // state and byte counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= itrd_pkg::ST_IDLE;
      byte_cnt_r <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    byte_cnt_nxt = byte_cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      itrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = itrd_pkg::ST_CHECK;
        end
      end
      itrd_pkg::ST_CHECK: begin
        byte_cnt_nxt = 2'd0;
        state_nxt    = st.table_ok ? itrd_pkg::ST_DIV : itrd_pkg::ST_EMPTY;
      end
      itrd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (byte_cnt_r == 2'd3);
        byte_cnt_nxt = byte_cnt_r + 2'd1;
        if (cmd.div_last && st.div_done) begin
          state_nxt = st.neg ? itrd_pkg::ST_SIGN : itrd_pkg::ST_EMIT;
        end
      end
      itrd_pkg::ST_SIGN: begin
        if (st.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = itrd_pkg::ST_EMIT;
        end
      end
      itrd_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          if (st.emit_last) begin
            state_nxt = itrd_pkg::ST_IDLE;
          end
        end
      end
      itrd_pkg::ST_EMPTY: begin
        if (st.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = itrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/itrd_dpath.sv -----
module itrd_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [itrd_pkg::VALUE_W-1:0] in_value,
  input  itrd_pkg::itrd_cmd_t                 cmd,
  output itrd_pkg::itrd_stat_t                st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last,
  output logic                                out_empty_res
);

  logic [itrd_pkg::RADIX_W-1:0]   radix_r;
  logic [itrd_pkg::SYM_W-1:0]     sym_low_r, sym_high_r;
  logic                           table_ok_r, table_ok_nxt;
  logic [itrd_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [itrd_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic                           neg_r;
  logic [itrd_pkg::CNT_W-1:0]     cnt_r;
  logic [itrd_pkg::DIGIT_W-1:0]   digit_store [itrd_pkg::DIGITS];
  logic [itrd_pkg::CHAR_W-1:0]    syms [itrd_pkg::NUM_SYMS];
  logic [itrd_pkg::CNT_W-1:0]     rd_cnt;
  logic [itrd_pkg::DIGIT_W-1:0]   rd_digit;
  logic                           out_valid_r;
  logic [itrd_pkg::CHAR_W-1:0]    out_char_r;
  logic                           out_last_r, out_empty_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= itrd_pkg::RADIX_RST;
      sym_low_r  <= itrd_pkg::SYM_LOW_RST;
      sym_high_r <= itrd_pkg::SYM_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        itrd_pkg::REG_RADIX:    radix_r    <= cfg_data[itrd_pkg::RADIX_W-1:0];
        itrd_pkg::REG_SYM_LOW:  sym_low_r  <= cfg_data;
        itrd_pkg::REG_SYM_HIGH: sym_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // symbol table split into bytes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      syms[i]     = sym_low_r[i*8 +: 8];
      syms[i + 8] = sym_high_r[i*8 +: 8];
    end
  end

  // table check: radix range, forbidden symbols, all pairs distinct
  always_comb begin
    table_ok_nxt = radix_r inside
                   {[itrd_pkg::RADIX_W'(2):itrd_pkg::RADIX_W'(itrd_pkg::MAX_RADIX)]};
    for (int i = 0; i < itrd_pkg::NUM_SYMS; i++) begin
      if (itrd_pkg::RADIX_W'(i) < radix_r) begin
        if (syms[i] inside {itrd_pkg::CHAR_PLUS, itrd_pkg::CHAR_MINUS}) begin
          table_ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < itrd_pkg::NUM_SYMS; j++) begin
          if ((itrd_pkg::RADIX_W'(j) < radix_r) && (syms[j] == syms[i])) begin
            table_ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_ok_r <= 1'b0;
    end else begin
      table_ok_r <= table_ok_nxt;
    end
  end

  // one byte of restoring division by the radix per cycle
  always_comb begin
    logic [itrd_pkg::RADIX_W-1:0] t;
    logic [7:0]                   qbyte;
    logic [itrd_pkg::DIGIT_W-1:0] rem;
    rem   = rem_r;
    qbyte = 8'd0;
    for (int k = 7; k >= 0; k--) begin
      t = {rem, mag_r[24 + k]};
      if (t >= radix_r) begin
        t        = t - radix_r;
        qbyte[k] = 1'b1;
      end
      rem = t[itrd_pkg::DIGIT_W-1:0];
    end
    rem_nxt = rem;
    mag_nxt = {mag_r[23:0], qbyte};
  end

  // magnitude, sign, digit count and digit store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      rem_r <= '0;
      neg_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.load) begin
      neg_r <= in_value[itrd_pkg::VALUE_W-1];
      mag_r <= in_value[itrd_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
      if (cmd.div_last) begin
        digit_store[cnt_r[itrd_pkg::DIG_IDX_W-1:0]] <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        rem_r <= '0;
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (cmd.emit_digit) begin
      cnt_r <= rd_cnt;
    end
  end

  // digits are read back most significant first
  assign rd_cnt   = cnt_r - 1'b1;
  assign rd_digit = digit_store[rd_cnt[itrd_pkg::DIG_IDX_W-1:0]];

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r  <= itrd_pkg::CHAR_MINUS;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r  <= syms[rd_digit];
      out_last_r  <= (cnt_r == itrd_pkg::CNT_W'(1));
      out_empty_r <= 1'b0;
    end else if (cmd.emit_empty) begin
      out_char_r  <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

  // status to the controller
  assign st.table_ok  = table_ok_r;
  assign st.div_done  = (mag_nxt == '0) ||
                        (cnt_r == itrd_pkg::CNT_W'(itrd_pkg::DIGITS - 1));
  assign st.neg       = neg_r;
  assign st.out_free  = !out_valid_r || out_ready;
  assign st.emit_last = (cnt_r == itrd_pkg::CNT_W'(1));

  // checks
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit || cmd.emit_empty) |-> st.out_free)
    else $error("word emitted while output slot busy");

  a_digit_present: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> (cnt_r != '0))
    else $error("digit emitted with no digits stored");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> ({1'b0, rem_r} < radix_r))
    else $error("division remainder not below radix");

  a_div_valid_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> table_ok_r)
    else $error("division started with invalid symbol table");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty result not marked last");

endmodule

// ----- rtl/core/integer_to_radix_digits_top.sv -----
// Converts a signed 32-bit value to text in a configurable radix (2 to 16), one character
// word per output transfer, most significant first, a leading '-' for negatives and last
// set on the final character; an invalid radix or symbol table gives one empty word.
// One item at a time: after acceptance the table is checked, then each digit is found by
// dividing the magnitude a byte at a time in the shared divide-by-radix unit (8 quotient
// bits per cycle), then the characters follow, one per cycle while the output accepts them
// (an item has 1 to 32 digits; decimal is at most 10).
module integer_to_radix_digits_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [itrd_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last,
  output logic                                out_empty_res
);

  itrd_pkg::itrd_cmd_t  cmd;
  itrd_pkg::itrd_stat_t st;

  // sequencer
  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // divider, digit store and output register
  itrd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value      (in_value),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_WORDS  = 24;
  localparam int RAND_PHASES  = 10;

  // one expected character word
  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic                        empty_res;
  } char_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [itrd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [itrd_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [31:0]             in_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [itrd_pkg::CHAR_W-1:0]    out_character;
  logic                           out_last;
  logic                           out_empty_res;

  // shadow copy of the configuration
  logic [itrd_pkg::RADIX_W-1:0] radix_cfg = itrd_pkg::RADIX_RST;
  logic [itrd_pkg::SYM_W-1:0]   sym_low_cfg = itrd_pkg::SYM_LOW_RST;
  logic [itrd_pkg::SYM_W-1:0]   sym_high_cfg = itrd_pkg::SYM_HIGH_RST;

  logic [31:0] value_queue [$];
  char_word_t  expected_chars [$];
  logic        in_taken = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          values_sent = 0;
  int          chars_checked = 0;
  int          table_writes = 0;
  int          bad_tables = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  integer_to_radix_digits_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // symbol byte from the shadow table
  function automatic logic [7:0] sym_byte(int unsigned idx);
    logic [63:0] bank;
    bank = idx[3] ? sym_high_cfg : sym_low_cfg;
    return bank[(idx % 8) * 8 +: 8];
  endfunction

  // used symbols must be distinct and never a sign character
  function automatic bit table_ok(int unsigned r);
    int unsigned i, j;
    if (!(r inside {[2:itrd_pkg::MAX_RADIX]})) return 1'b0;
    for (i = 0; i < r; i++) begin
      if (sym_byte(i) inside {itrd_pkg::CHAR_PLUS, itrd_pkg::CHAR_MINUS}) return 1'b0;
      for (j = i + 1; j < r; j++)
        if (sym_byte(j) == sym_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the text of one value, sign first, most significant digit next
  function automatic void predict_text(logic [31:0] v);
    logic [32:0] mag;
    logic [3:0]  digs [32];
    int unsigned r;
    int          n, total, k, i;
    bit          neg;
    char_word_t  w;
    r = radix_cfg;
    if (!table_ok(r)) begin
      w.ch = '0;
      w.last = 1'b1;
      w.empty_res = 1'b1;
      expected_chars.push_back(w);
      return;
    end
    neg = v[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    n = 0;
    do begin
      digs[n] = 4'(mag % r);
      mag = mag / r;
      n++;
    end while (mag != 0 && n < 32);
    total = n + neg;
    k = 0;
    w.empty_res = 1'b0;
    if (neg) begin
      w.ch = itrd_pkg::CHAR_MINUS;
      w.last = (total == 1);
      expected_chars.push_back(w);
      k++;
    end
    for (i = n - 1; i >= 0; i--) begin
      w.ch = sym_byte(digs[i]);
      w.last = (k + 1 == total);
      expected_chars.push_back(w);
      k++;
    end
  endfunction

  // values biased toward extremes, small numbers and digit-count edges
  function automatic logic [31:0] random_value();
    logic [31:0] v, p;
    int unsigned r, sel;
    r = radix_cfg;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(40);
      5: v = 32'h7fff_ffff - $urandom_range(3);
      6: v = 32'h8000_0000 + $urandom_range(3);
      7: begin
        if (r inside {[2:itrd_pkg::MAX_RADIX]}) begin
          p = 1;
          repeat ($urandom_range(31))
            if (p <= 32'h7fff_ffff / r) p = p * r;
          v = p - 1 + $urandom_range(2);
        end else begin
          v = $urandom;
        end
      end
      8: v = $urandom_range(2) - 1;
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ((sel inside {4, 7, 9}) && $urandom_range(1)) v = -v;
    return v;
  endfunction

  // input driver: a new word only once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (value_queue.size() > 0 && $urandom_range(99) >= (quiet ? 0 : 25)) begin
        in_valid <= 1'b1;
        in_value <= value_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken <= 1'b0;
  end

  // output side: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && chars_checked >= 100 && value_queue.size() > 8) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= (quiet ? 0 : 25));
    end
  end

  // accepted words in, character words out
  always @(posedge clk) begin
    char_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_text(in_value);
        values_sent++;
        in_taken <= 1'b1;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: char %h last %b empty %b", out_character,
                     out_last, out_empty_res);
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.ch || out_last !== want.last ||
              out_empty_res !== want.empty_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected char %h last %b empty %b, got %h %b %b",
                       want.ch, want.last, want.empty_res, out_character, out_last,
                       out_empty_res);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d characters still expected", expected_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [itrd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [itrd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      itrd_pkg::REG_RADIX:    radix_cfg = data[itrd_pkg::RADIX_W-1:0];
      itrd_pkg::REG_SYM_LOW:  sym_low_cfg = data;
      itrd_pkg::REG_SYM_HIGH: sym_high_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_table(input logic [itrd_pkg::RADIX_W-1:0] r, input logic [63:0] lo,
                             input logic [63:0] hi);
    write_reg(itrd_pkg::REG_RADIX, {{(itrd_pkg::CFG_W-itrd_pkg::RADIX_W){1'b0}}, r});
    write_reg(itrd_pkg::REG_SYM_LOW, lo);
    write_reg(itrd_pkg::REG_SYM_HIGH, hi);
    table_writes++;
    if (!table_ok(r)) bad_tables++;
  endtask

  // wait until all words are sent and all characters have come back
  task automatic drain();
    do @(posedge clk);
    while (value_queue.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // random table, sometimes broken on purpose
  task automatic pick_table(input bit make_bad);
    logic [7:0]                   syms [16];
    logic [63:0]                  lo, hi;
    logic [itrd_pkg::RADIX_W-1:0] r;
    int                           i, j;
    bit                           clash;
    case ($urandom_range(3))
      0: r = itrd_pkg::RADIX_W'(2);
      1: r = itrd_pkg::RADIX_W'(itrd_pkg::MAX_RADIX);
      default: r = itrd_pkg::RADIX_W'($urandom_range(2, itrd_pkg::MAX_RADIX));
    endcase
    for (i = 0; i < 16; i++) syms[i] = 8'($urandom_range(255));
    for (i = 0; i < r; i++) begin
      clash = 1'b1;
      while (clash) begin
        syms[i] = 8'($urandom_range(255));
        clash = syms[i] inside {itrd_pkg::CHAR_PLUS, itrd_pkg::CHAR_MINUS};
        for (j = 0; j < i; j++)
          if (syms[j] == syms[i]) clash = 1'b1;
      end
    end
    if (make_bad) begin
      case ($urandom_range(2))
        0: r = itrd_pkg::RADIX_W'($urandom_range(1) ? $urandom_range(1)
                                                     : $urandom_range(17, 31));
        1: syms[$urandom_range(r - 1)] = $urandom_range(1) ? itrd_pkg::CHAR_PLUS
                                                            : itrd_pkg::CHAR_MINUS;
        default: begin
          i = $urandom_range(r - 1);
          j = (i + 1 + $urandom_range(r - 2)) % r;
          syms[j] = syms[i];
        end
      endcase
    end
    for (i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = syms[i];
      hi[i*8 +: 8] = syms[i+8];
    end
    write_table(r, lo, hi);
  endtask

  localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HI = 64'h6665_6463_6261_3938;
  localparam logic [63:0] BYTE5  = 64'hff << 40;

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // decimal table straight out of reset
    value_queue.push_back(0);
    value_queue.push_back(1);
    value_queue.push_back(-1);
    value_queue.push_back(7);
    value_queue.push_back(10);
    value_queue.push_back(-123456789);
    value_queue.push_back(32'h7fff_ffff);
    value_queue.push_back(32'h8000_0000);
    drain();

    // hexadecimal
    write_table(16, HEX_LO, HEX_HI);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(32'h7fff_ffff);
    value_queue.push_back(32'hdead_beef);
    value_queue.push_back(255);
    drain();

    // binary with byte zero as an ordinary symbol, longest text
    write_table(2, 64'h0100, 64'h0);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(-1);
    value_queue.push_back(5);
    drain();

    // radix out of range: zero, one, just above and far above the maximum
    write_table(0, HEX_LO, HEX_HI);
    value_queue.push_back(42);
    drain();
    write_table(1, HEX_LO, HEX_HI);
    value_queue.push_back(-42);
    drain();
    write_table(17, HEX_LO, HEX_HI);
    value_queue.push_back(32'h8000_0000);
    drain();
    write_table(31, HEX_LO, HEX_HI);
    value_queue.push_back(0);
    drain();

    // plus sign among the used symbols
    write_table(16, (HEX_LO & ~BYTE5) | ({56'd0, itrd_pkg::CHAR_PLUS} << 40), HEX_HI);
    value_queue.push_back(1000);
    drain();

    // minus sign as symbol zero
    write_table(10, {HEX_LO[63:8], itrd_pkg::CHAR_MINUS}, itrd_pkg::SYM_HIGH_RST);
    value_queue.push_back(-7);
    drain();

    // repeated symbol far apart in the table
    write_table(16, HEX_LO, (HEX_HI & ~BYTE5) | (64'h32 << 40));
    value_queue.push_back(12345);
    drain();

    // sign characters only in unused slots: still a valid octal table
    write_table(8, HEX_LO, {48'd0, itrd_pkg::CHAR_MINUS, itrd_pkg::CHAR_PLUS});
    value_queue.push_back(-8);
    drain();

    // random tables and values
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      pick_table(ph > 0 && $urandom_range(4) == 0);
      quiet = (ph == 4);
      repeat (PHASE_WORDS) value_queue.push_back(random_value());
      drain();
    end
    quiet = 1'b0;

    repeat (200) @(posedge clk);
    if (expected_chars.size() != 0) mismatches++;

    $display("%0d values converted, %0d characters checked, %0d tables written (%0d invalid)",
             values_sent, chars_checked, table_writes, bad_tables);
    $display("cycles %0d, mismatches %0d", cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
